// File: src/hwpp_pkg.sv
// Shared types, codes and character helpers for the hex wildcard pattern packer.
package hwpp_pkg;

  // Default width of the saturating wildcard counters.
  localparam int unsigned CNT_BITS_DEF = 16;

  // Depth of the result queue and its index width.
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);

  // Result kinds.
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Report status codes, also used as the sticky error code.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HALF_WC  = 3'd1;
  localparam logic [2:0] ST_ODD_NIB  = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_BAD_CHAR = 3'd4;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // One input word: a pattern character.
  typedef struct packed {
    logic [7:0] char_code;
    logic       final_char;
  } in_word_t;

  // One result word: a concrete byte or the final report.
  typedef struct packed {
    logic        kind;
    logic [7:0]  byte_value;
    logic [15:0] gap_before;
    logic [15:0] lead_skip;
    logic [2:0]  status;
    logic        end_of_run;
  } out_word_t;

  // Results made by one character, first one first.
  typedef struct packed {
    logic [1:0] n;
    out_word_t  first;
    out_word_t  second;
  } parse_res_t;

  // Whitespace: tab through carriage return, and space.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
  endfunction

  // Hex digit decode: bit 4 is set for a digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c inside {["0":"9"]}) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if (c inside {["a":"f"]}) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end else if (c inside {["A":"F"]}) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// File: src/hwpp_parse.sv
// Per-character parser: pattern state registers and the next-state and result logic.
module hwpp_parse #(
  parameter int unsigned COUNT_BITS = hwpp_pkg::CNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  hwpp_pkg::in_word_t   in_word,
  output hwpp_pkg::parse_res_t res
);
  import hwpp_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam int unsigned EXT_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  // Saturating increment of a wildcard counter.
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Counter value clipped to the 16-bit result field.
  function automatic logic [15:0] out16(input logic [COUNT_BITS-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return (e > EXT_W'(17'h0FFFF)) ? 16'hFFFF : e[15:0];
  endfunction

  // Pattern state.
  logic                  lnn_r, lnn_nxt;     // low nibble expected next
  logic [3:0]            hi_r, hi_nxt;       // high nibble held
  logic                  qh_r, qh_nxt;       // second '?' awaiting next character
  logic                  pw_r, pw_nxt;       // last character was a byte-start '?'
  logic                  seen_r, seen_nxt;   // a concrete byte has been emitted
  logic [COUNT_BITS-1:0] lead_r, lead_nxt;
  logic [COUNT_BITS-1:0] gap_r, gap_nxt;
  logic [2:0]            err_r, err_nxt;

  logic       blank;
  logic [4:0] hv;
  logic       handled;
  out_word_t  byte_w;
  out_word_t  rep_w;
  logic [2:0] st;

  // Next state and results for the character in the input register.
  always_comb begin
    lnn_nxt  = lnn_r;
    hi_nxt   = hi_r;
    qh_nxt   = qh_r;
    pw_nxt   = pw_r;
    seen_nxt = seen_r;
    lead_nxt = lead_r;
    gap_nxt  = gap_r;
    err_nxt  = err_r;
    blank    = is_blank(in_word.char_code);
    hv       = hex_value(in_word.char_code);
    handled  = 1'b0;
    byte_w   = '0;
    rep_w    = '0;
    st       = ST_OK;
    res      = '0;

    // A held second '?' is absorbed by whitespace, else it is a wildcard itself.
    if (err_r == ST_OK && qh_r) begin
      qh_nxt = 1'b0;
      if (blank) begin
        pw_nxt  = 1'b0;
        handled = 1'b1;
      end else begin
        if (seen_r) gap_nxt = sat_inc(gap_r);
        else lead_nxt = sat_inc(lead_r);
        pw_nxt = 1'b1;
      end
    end

    // Regular character handling.
    if (err_r == ST_OK && !handled) begin
      if (blank) begin
        pw_nxt = 1'b0;
      end else if (in_word.char_code == CH_QUERY) begin
        if (lnn_r) begin
          err_nxt = ST_HALF_WC;
        end else if (pw_nxt) begin
          qh_nxt = 1'b1;
          pw_nxt = 1'b0;
        end else begin
          if (seen_r) gap_nxt = sat_inc(gap_nxt);
          else lead_nxt = sat_inc(lead_nxt);
          pw_nxt = 1'b1;
        end
      end else begin
        pw_nxt = 1'b0;
        if (!hv[4]) begin
          err_nxt = ST_BAD_CHAR;
        end else if (!lnn_r) begin
          hi_nxt  = hv[3:0];
          lnn_nxt = 1'b1;
        end else begin
          byte_w.kind       = KIND_BYTE;
          byte_w.byte_value = {hi_r, hv[3:0]};
          byte_w.gap_before = seen_r ? out16(gap_nxt) : 16'd0;
          res.first         = byte_w;
          res.n             = 2'd1;
          seen_nxt          = 1'b1;
          gap_nxt           = '0;
          lnn_nxt           = 1'b0;
        end
      end
    end

    // Final character: report, then back to the reset state.
    if (in_word.final_char) begin
      if (err_nxt != ST_OK) st = err_nxt;
      else if (lnn_nxt) st = ST_ODD_NIB;
      else if (!seen_nxt) st = ST_EMPTY;
      else st = ST_OK;
      rep_w.kind       = KIND_REPORT;
      rep_w.lead_skip  = out16(lead_nxt);
      rep_w.status     = st;
      rep_w.end_of_run = 1'b1;
      if (res.n == 2'd0) res.first = rep_w;
      else res.second = rep_w;
      res.n    = res.n + 2'd1;
      lnn_nxt  = 1'b0;
      hi_nxt   = 4'd0;
      qh_nxt   = 1'b0;
      pw_nxt   = 1'b0;
      seen_nxt = 1'b0;
      lead_nxt = '0;
      gap_nxt  = '0;
      err_nxt  = ST_OK;
    end
  end

  // State registers advance once per processed character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lnn_r  <= 1'b0;
      hi_r   <= 4'd0;
      qh_r   <= 1'b0;
      pw_r   <= 1'b0;
      seen_r <= 1'b0;
      lead_r <= '0;
      gap_r  <= '0;
      err_r  <= ST_OK;
    end else if (step) begin
      lnn_r  <= lnn_nxt;
      hi_r   <= hi_nxt;
      qh_r   <= qh_nxt;
      pw_r   <= pw_nxt;
      seen_r <= seen_nxt;
      lead_r <= lead_nxt;
      gap_r  <= gap_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

// File: src/hwpp_outq.sv
// Result queue: takes up to two words per cycle and hands out one word at a time.
module hwpp_outq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  hwpp_pkg::parse_res_t       res,
  output logic [hwpp_pkg::OQ_AW:0]   cnt,
  output logic                       out_valid,
  input  logic                       out_ready,
  output hwpp_pkg::out_word_t        out_data
);
  import hwpp_pkg::*;

  out_word_t        mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_r, wr_nxt;
  logic [OQ_AW-1:0] rd_r, rd_nxt;
  logic [OQ_AW:0]   cnt_r, cnt_nxt;
  logic [1:0]       n_push;
  logic             pop;

  assign n_push    = push ? res.n : 2'd0;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_r];
  assign cnt       = cnt_r;

  // Pointer and fill-count arithmetic.
  always_comb begin
    wr_nxt  = wr_r + OQ_AW'(n_push);
    rd_nxt  = rd_r + OQ_AW'(pop);
    cnt_nxt = cnt_r + (OQ_AW+1)'(n_push) - (OQ_AW+1)'(pop);
  end

  // Storage writes: first word at the write pointer, second just after it.
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem[wr_r] <= res.first;
    if (n_push == 2'd2) mem[wr_r + OQ_AW'(1)] <= res.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: src/hex_wildcard_pattern_packer_core.sv
// Top level of the hex wildcard pattern packer: input register, parser and result queue.
// Flow: a character is registered on acceptance and its words enter the result
// queue when the parser processes the held character; words are offered from the queue.
// Throughput: one character per cycle; the parser waits only while the four-word
// result queue has fewer than two free entries, i.e. when the output side stalls.
// Reset: rst_n is synchronous and active low; it empties the pipeline and queue
// and returns the parser to the start of a new pattern.
module hex_wildcard_pattern_packer_core #(
  parameter int unsigned COUNT_BITS = hwpp_pkg::CNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hwpp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hwpp_pkg::out_word_t out_data
);
  import hwpp_pkg::*;

  logic           in_v_r, in_v_nxt;
  in_word_t       in_word_r;
  logic           adv;
  parse_res_t     res;
  logic [OQ_AW:0] q_cnt;

  // The held word is processed when the queue has room for two results.
  assign adv      = in_v_r && (q_cnt <= (OQ_AW+1)'(OQ_DEPTH - 2));
  assign in_ready = !in_v_r || adv;
  assign in_v_nxt = (in_valid && in_ready) || (in_v_r && !adv);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_word_r <= in_data;
  end

  hwpp_parse #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .in_word (in_word_r),
    .res     (res)
  );

  hwpp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .res       (res),
    .cnt       (q_cnt),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Two results from one character are a concrete byte followed by the report.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.n == 2'd2) |-> (res.first.kind == KIND_BYTE &&
                                res.second.kind == KIND_REPORT))
    else $error("two results not ordered byte then report");

  // A report is produced exactly when the final character is processed.
  a_report_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> ((res.n != 2'd0 &&
              (res.n == 2'd2 ? res.second.kind : res.first.kind) == KIND_REPORT)
             == in_word_r.final_char))
    else $error("final report does not match final character");

  // The queue never overfills.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= (OQ_AW+1)'(OQ_DEPTH))
    else $error("result queue overflow");

  // A stalled input means a held word waiting on a nearly full queue.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_v_r && q_cnt > (OQ_AW+1)'(OQ_DEPTH - 2)))
    else $error("input stalled without cause");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the hex wildcard pattern packer core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hwpp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned LONG_RUN     = 48;

  // Predicts the words of each accepted character and checks them in order.
  class pattern_parse_board;
    localparam longint unsigned COUNT_CAP = (64'd1 << CNT_BITS_DEF) - 1;

    bit              low_next;
    bit [3:0]        high_nib;
    bit              query_wait;
    bit              after_wild;
    bit              got_byte;
    longint unsigned lead_cnt;
    longint unsigned gap_cnt;
    logic [2:0]      err_code;
    out_word_t       pending_words[$];
    int unsigned     errors;

    function new();
      clear();
      errors = 0;
    endfunction

    // Parser state at the start of a pattern.
    function void clear();
      low_next   = 0;
      high_nib   = 4'd0;
      query_wait = 0;
      after_wild = 0;
      got_byte   = 0;
      lead_cnt   = 0;
      gap_cnt    = 0;
      err_code   = ST_OK;
    endfunction

    // Appends one expected word at the tail.
    function void add_word(out_word_t o);
      pending_words.insert(pending_words.size(), o);
    endfunction

    function bit is_space(logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function int digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      return -1;
    endfunction

    function logic [15:0] clip16(longint unsigned v);
      return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    // A whole-byte wildcard counts as leading until the first concrete byte.
    function void count_wild();
      if (got_byte) begin
        gap_cnt = (gap_cnt < COUNT_CAP) ? gap_cnt + 1 : COUNT_CAP;
      end else begin
        lead_cnt = (lead_cnt < COUNT_CAP) ? lead_cnt + 1 : COUNT_CAP;
      end
    endfunction

    function void take_char(in_word_t w);
      logic [7:0] c;
      bit         skip;
      int         d;
      out_word_t  o;
      c = w.char_code;
      skip = 0;
      // A held second '?' is absorbed by whitespace, otherwise it stands alone.
      if (err_code == ST_OK && query_wait) begin
        query_wait = 0;
        if (is_space(c)) begin
          after_wild = 0;
          skip = 1;
        end else begin
          count_wild();
          after_wild = 1;
        end
      end
      if (err_code == ST_OK && !skip) begin
        if (is_space(c)) begin
          after_wild = 0;
        end else if (c == CH_QUERY) begin
          if (low_next) begin
            err_code = ST_HALF_WC;
          end else if (after_wild) begin
            query_wait = 1;
            after_wild = 0;
          end else begin
            count_wild();
            after_wild = 1;
          end
        end else begin
          d = digit_of(c);
          after_wild = 0;
          if (d < 0) begin
            err_code = ST_BAD_CHAR;
          end else if (!low_next) begin
            high_nib = d[3:0];
            low_next = 1;
          end else begin
            o = '0;
            o.kind = KIND_BYTE;
            o.byte_value = {high_nib, d[3:0]};
            o.gap_before = got_byte ? clip16(gap_cnt) : 16'd0;
            add_word(o);
            got_byte = 1;
            gap_cnt = 0;
            low_next = 0;
          end
        end
      end
      // The last character closes the pattern with a report.
      if (w.final_char) begin
        o = '0;
        o.kind = KIND_REPORT;
        o.lead_skip = clip16(lead_cnt);
        o.end_of_run = 1'b1;
        if (err_code != ST_OK) o.status = err_code;
        else if (low_next) o.status = ST_ODD_NIB;
        else if (!got_byte) o.status = ST_EMPTY;
        else o.status = ST_OK;
        add_word(o);
        clear();
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (pending_words.size() == 0) begin
        $display("%0t: word with nothing expected, expected none, got %p", $time, got);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("byte_value", 16'(want.byte_value), 16'(got.byte_value));
      compare_field("gap_before", want.gap_before, got.gap_before);
      compare_field("lead_skip", want.lead_skip, got.lead_skip);
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("end_of_run", 16'(want.end_of_run), 16'(got.end_of_run));
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  bit               quiet;
  int unsigned      items_sent;
  int unsigned      cycle_count;
  byte unsigned     pattern_chars[$];
  pattern_parse_board parse_board = new();

  hex_wildcard_pattern_packer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short idle stretches, now and then a long one; none while quiet.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic byte unsigned hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return byte'(48 + v);
    return byte'(($urandom_range(0, 1) ? 97 : 65) + v - 10);
  endfunction

  function automatic byte unsigned blank_char();
    int r;
    r = $urandom_range(0, 7);
    return (r < 3) ? CH_SPACE : byte'(9 + r - 3);
  endfunction

  // Both handshakes are seen here, at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) parse_board.take_char(in_data);
    if (rst_n && out_valid && out_ready) parse_board.check_word(out_data);
  end

  // Result side: random stalls.
  initial begin
    int hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        hold = pick_idle();
        if (hold == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          hold--;
        end
      end
    end
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // Offers one word and returns at the falling edge after it is taken.
  task automatic send_char(input logic [7:0] c, input logic fin);
    int idle;
    idle = pick_idle();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_code: c, final_char: fin};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Appends one character to the pattern being built.
  function automatic void add_char(input byte unsigned c);
    pattern_chars.insert(pattern_chars.size(), c);
  endfunction

  task automatic send_pattern();
    for (int i = 0; i < pattern_chars.size(); i++) begin
      send_char(pattern_chars[i], i == pattern_chars.size() - 1);
    end
    pattern_chars.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    send_pattern();
  endtask

  // Holds the sender until every expected word has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (parse_board.pending_words.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly well-formed patterns with random content, some noise mixed in.
  task automatic build_random_pattern();
    int ntok;
    int r;
    ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 8);
    for (int t = 0; t < ntok; t++) begin
      if ($urandom_range(0, 2) != 0) add_char(blank_char());
      r = $urandom_range(0, 99);
      if (r < 55) begin
        add_char(hex_char());
        if ($urandom_range(0, 19) == 0) add_char(blank_char());
        add_char(hex_char());
      end else if (r < 80) begin
        add_char(CH_QUERY);
      end else if (r < 92) begin
        add_char(CH_QUERY);
        add_char(CH_QUERY);
      end else if (r < 96) begin
        add_char(byte'($urandom_range(0, 255)));
      end else begin
        add_char(hex_char());
      end
    end
    if (pattern_chars.size() == 0 || $urandom_range(0, 4) == 0) begin
      add_char(blank_char());
    end
  endtask

  initial begin
    int patterns;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    quiet = 1'b0;
    items_sent = 0;
    patterns = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: absorbed second query, final character finishing a byte.
    send_text("?? 0a");
    // First error sticks and outranks the odd nibble; top code is a bad character.
    pattern_chars = '{8'h33, 8'hFF, CH_QUERY, 8'h34};
    send_pattern();
    // Whitespace only, wildcard only, half-byte wildcard, odd nibble.
    pattern_chars = '{8'd9, 8'd13};
    send_pattern();
    send_text("??");
    send_text("1?");
    send_text("F");
    // Code zero is a bad character.
    pattern_chars = '{8'h00};
    send_pattern();
    // Inner wildcard gap, then a trailing wildcard that is dropped.
    send_text("Bc?? ?9d?");
    drain();

    // Long wildcard runs back to back: a leading run, then an inner gap.
    quiet = 1'b1;
    for (int i = 0; i < LONG_RUN; i++) send_char(CH_QUERY, 1'b0);
    send_text("5a");
    send_char("5", 1'b0);
    send_char("a", 1'b0);
    for (int i = 0; i < LONG_RUN; i++) send_char(CH_QUERY, 1'b0);
    send_text("a5");
    drain();
    quiet = 1'b0;

    // Random patterns, with quiet stretches and occasional full drains.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (patterns % 8 == 0) quiet = ($urandom_range(0, 4) == 0);
      build_random_pattern();
      send_pattern();
      patterns++;
      if (patterns % 40 == 0) drain();
    end

    drain();
    repeat (8) @(posedge clk);
    if (parse_board.errors == 0 && parse_board.pending_words.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
